FILE: rtl/npcm_pkg.sv
package npcm_pkg;

  localparam int PAL_COUNT = 11;
  localparam int DIST_W    = 18;
  localparam int IDX_W     = 4;

  localparam logic [7:0] SPACE_CODE  = 8'd32;
  localparam logic [7:0] GLYPH_RESET = 8'd35;

  // Entry 0 is never searched; the chain covers entries 1 to PAL_COUNT-1.
  localparam logic [7:0] PAL_R [PAL_COUNT] =
    '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255};
  localparam logic [7:0] PAL_G [PAL_COUNT] =
    '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd166, 8'd85};
  localparam logic [7:0] PAL_B [PAL_COUNT] =
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } npcm_pixel_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [IDX_W-1:0] color_index;
  } npcm_cell_t;

  // Word handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              transparent;
    logic [DIST_W-1:0] best_d;
    logic [IDX_W-1:0]  best_idx;
  } npcm_link_t;

endpackage

FILE: rtl/nearest_palette_cell_mapper_unit.sv
// Maps one RGBA pixel to one text cell: a space for a fully transparent pixel, else the
// glyph register (reset 35), and the index 1 to 10 of the nearest palette color by squared
// RGB distance, lower index on a tie. A pixel passes through a row of ten cells, one per
// palette entry, each comparing against the best so far; a pixel is accepted every clock
// while the row advances, and its cell word is offered once it reaches the last cell,
// one register stage per cell. The whole row stalls only while the output word waits.
// Write glyph only while the row is empty.
module nearest_palette_cell_mapper_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  npcm_pkg::npcm_pixel_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output npcm_pkg::npcm_cell_t  out_data,
  input  logic                 glyph_we,
  input  logic [7:0]           glyph_wdata
);
  import npcm_pkg::*;

  localparam int N = PAL_COUNT - 1;

  npcm_link_t link [N+1];
  logic       advance;
  logic [7:0] glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph <= GLYPH_RESET;
    end else if (glyph_we) begin
      glyph <= glyph_wdata;
    end
  end

  assign advance  = !link[N].valid || out_ready;
  assign in_ready = advance;

  always_comb begin
    link[0].valid       = in_valid;
    link[0].red         = in_data.red;
    link[0].green       = in_data.green;
    link[0].blue        = in_data.blue;
    link[0].transparent = in_data.alpha == 8'd0;
    link[0].best_d      = '1;
    link[0].best_idx    = IDX_W'(1);
  end

  for (genvar k = 1; k <= N; k++) begin : g_cell
    npcm_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .link_in  (link[k-1]),
      .link_out (link[k])
    );
  end

  assign out_valid             = link[N].valid;
  assign out_data.cell_char    = link[N].transparent ? SPACE_CODE : glyph;
  assign out_data.color_index  = link[N].best_idx;

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.color_index >= IDX_W'(1) &&
                   out_data.color_index <= IDX_W'(N)))
    else $error("color index out of range");

  a_empty_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_char_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cell_char == SPACE_CODE || out_data.cell_char == glyph))
    else $error("cell character is neither space nor glyph");
`endif

endmodule

FILE: rtl/npcm_cell.sv
module npcm_cell #(
  parameter int IDX = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  npcm_pkg::npcm_link_t link_in,
  output npcm_pkg::npcm_link_t link_out
);
  import npcm_pkg::*;

  logic [7:0]        dr, dg, db;
  logic [15:0]       sr, sg, sb;
  logic [DIST_W-1:0] cand_d;
  logic              closer;
  npcm_link_t        word;

  always_comb begin
    dr = (link_in.red > PAL_R[IDX]) ? link_in.red - PAL_R[IDX] : PAL_R[IDX] - link_in.red;
    dg = (link_in.green > PAL_G[IDX]) ? link_in.green - PAL_G[IDX]
                                      : PAL_G[IDX] - link_in.green;
    db = (link_in.blue > PAL_B[IDX]) ? link_in.blue - PAL_B[IDX]
                                     : PAL_B[IDX] - link_in.blue;
    sr = 16'(dr) * 16'(dr);
    sg = 16'(dg) * 16'(dg);
    sb = 16'(db) * 16'(db);
    cand_d = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    // Strict compare keeps the lower index on a tie.
    closer = cand_d < link_in.best_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else if (advance) begin
      word.valid <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word.red         <= link_in.red;
      word.green       <= link_in.green;
      word.blue        <= link_in.blue;
      word.transparent <= link_in.transparent;
      word.best_d      <= closer ? cand_d : link_in.best_d;
      word.best_idx    <= closer ? IDX_W'(IDX) : link_in.best_idx;
    end
  end

  assign link_out = word;

endmodule

FILE: verif/tb_nearest_palette_cell_mapper_unit.sv
`timescale 1ns / 100ps

module tb_nearest_palette_cell_mapper_unit;
  import npcm_pkg::*;

  localparam int IDLE_PCT = 16;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] BLANK_CHAR = 8'd32;
  localparam logic [7:0] GLYPH_AT_RESET = 8'd35;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  npcm_pixel_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  npcm_cell_t out_data;
  logic glyph_we = 1'b0;
  logic [7:0] glyph_wdata = 8'd0;

  logic stalls_on = 1'b1;
  logic [7:0] glyph_now = GLYPH_AT_RESET;
  npcm_cell_t cell_q[$];
  npcm_cell_t want;
  logic [10:0] index_seen = '0;
  int errors = 0;
  int cells_checked = 0;
  int blank_pixels = 0;
  int glyph_phases = 1;
  int quiet_cycles = 0;

  nearest_palette_cell_mapper_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .glyph_we   (glyph_we),
    .glyph_wdata(glyph_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Searches entries 1 to 10 only; a strict compare keeps the lower index on a tie.
  function automatic logic [3:0] nearest_color(input logic [7:0] r, g, b);
    int ri, gi, bi, pr, pg, pb, d, best_d;
    logic [3:0] best;
    ri = r;
    gi = g;
    bi = b;
    best = 4'd1;
    best_d = 32'h7fffffff;
    for (int k = 1; k <= 10; k++) begin
      case (k)
        1: begin pr = 255; pg = 0;   pb = 0;   end
        2: begin pr = 0;   pg = 255; pb = 0;   end
        3: begin pr = 255; pg = 255; pb = 0;   end
        4: begin pr = 0;   pg = 0;   pb = 255; end
        5: begin pr = 255; pg = 0;   pb = 255; end
        6: begin pr = 0;   pg = 255; pb = 255; end
        7: begin pr = 255; pg = 255; pb = 255; end
        8: begin pr = 0;   pg = 0;   pb = 0;   end
        9: begin pr = 255; pg = 166; pb = 0;   end
        default: begin pr = 255; pg = 85; pb = 0; end
      endcase
      d = (ri - pr) * (ri - pr) + (gi - pg) * (gi - pg) + (bi - pb) * (bi - pb);
      if (d < best_d) begin
        best_d = d;
        best = k[3:0];
      end
    end
    return best;
  endfunction

  // Mostly uniform levels, with extra weight on the cube faces and on the
  // levels where the nearest entry flips between neighbors.
  function automatic logic [7:0] random_level();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 8'($urandom_range(0, 255));
    if (sel < 8) begin
      case ($urandom_range(0, 7))
        0: return 8'd42;
        1: return 8'd43;
        2: return 8'd125;
        3: return 8'd126;
        4: return 8'd127;
        5: return 8'd128;
        6: return 8'd210;
        default: return 8'd211;
      endcase
    end
    return $urandom_range(0, 1) ? 8'd255 : 8'd0;
  endfunction

  function automatic logic [7:0] random_alpha();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return 8'd0;
    if (sel == 2) return 8'd255;
    return 8'($urandom_range(1, 255));
  endfunction

  always @(posedge clk) begin
    out_ready <= stalls_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // Predicts on each accepted pixel word, checks each accepted cell word, and
  // ends the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        want.cell_char = (in_data.alpha == 8'd0) ? BLANK_CHAR : glyph_now;
        want.color_index = nearest_color(in_data.red, in_data.green, in_data.blue);
        cell_q.push_back(want);
        if (in_data.alpha == 8'd0) blank_pixels++;
      end
      if (out_valid && out_ready) begin
        cells_checked++;
        if (cell_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("cell %0d arrived with none expected: char %0d index %0d",
                     cells_checked, out_data.cell_char, out_data.color_index);
        end else begin
          want = cell_q.pop_front();
          index_seen[want.color_index] = 1'b1;
          if (out_data.cell_char !== want.cell_char ||
              out_data.color_index !== want.color_index) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("cell %0d: expected char %0d index %0d, got char %0d index %0d",
                       cells_checked, want.cell_char, want.color_index,
                       out_data.cell_char, out_data.color_index);
          end
        end
      end
      if (glyph_we) glyph_now = glyph_wdata;
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** nearest_palette_cell_mapper_unit: FAILED **");
        $finish;
      end
    end
  end

  // Valid is left high after acceptance; the next call either keeps it high
  // with a new word or drops it for a random gap.
  task automatic send_rgba(input logic [7:0] r, g, b, a);
    if (stalls_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data <= {r, g, b, a};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cell_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_glyph(input logic [7:0] value);
    wait_drained();
    glyph_we <= 1'b1;
    glyph_wdata <= value;
    @(posedge clk);
    glyph_we <= 1'b0;
    glyph_phases++;
  endtask

  task automatic test_corners();
    send_rgba(8'd255, 8'd0,   8'd0,   8'd255);
    send_rgba(8'd0,   8'd255, 8'd0,   8'd255);
    send_rgba(8'd255, 8'd255, 8'd0,   8'd255);
    send_rgba(8'd0,   8'd0,   8'd255, 8'd255);
    send_rgba(8'd255, 8'd0,   8'd255, 8'd255);
    send_rgba(8'd0,   8'd255, 8'd255, 8'd255);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd255);
    send_rgba(8'd255, 8'd166, 8'd0,   8'd255);
    send_rgba(8'd255, 8'd85,  8'd0,   8'd255);
    // Transparent pixels still carry a color index.
    send_rgba(8'd0,   8'd0,   8'd0,   8'd0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd0);
    send_rgba(8'd255, 8'd166, 8'd0,   8'd0);
    send_rgba(8'd127, 8'd127, 8'd127, 8'd1);
    send_rgba(8'd128, 8'd128, 8'd128, 8'd128);
    send_rgba(8'd42,  8'd0,   8'd0,   8'd255);
    send_rgba(8'd43,  8'd0,   8'd0,   8'd255);
    send_rgba(8'd255, 8'd125, 8'd0,   8'd255);
    send_rgba(8'd255, 8'd126, 8'd0,   8'd255);
    send_rgba(8'd255, 8'd210, 8'd0,   8'd255);
    send_rgba(8'd255, 8'd211, 8'd0,   8'd255);
    send_rgba(8'h55,  8'hAA,  8'h55,  8'h80);
    send_rgba(8'hAA,  8'h55,  8'hAA,  8'h7F);
  endtask

  task automatic test_glyph_values();
    logic [7:0] codes [6];
    codes[0] = 8'd0;
    codes[1] = 8'd255;
    codes[2] = 8'hA5;
    codes[3] = 8'h5A;
    codes[4] = BLANK_CHAR;
    codes[5] = GLYPH_AT_RESET;
    for (int i = 0; i < 6; i++) begin
      set_glyph(codes[i]);
      send_rgba(8'd10, 8'd20, 8'd30, 8'd0);
      send_rgba(8'd200, 8'd150, 8'd40, 8'd1);
      send_rgba(random_level(), random_level(), random_level(), 8'd255);
      send_rgba(random_level(), random_level(), random_level(), random_alpha());
    end
  endtask

  task automatic test_random_stream(input int count);
    for (int phase = 0; phase < 4; phase++) begin
      if (phase != 0) set_glyph(8'($urandom_range(0, 255)));
      for (int i = 0; i < count / 4; i++)
        send_rgba(random_level(), random_level(), random_level(), random_alpha());
    end
  endtask

  task automatic test_back_to_back(input int count);
    wait_drained();
    stalls_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_rgba(random_level(), random_level(), random_level(), random_alpha());
    wait_drained();
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_glyph_values();
    test_random_stream(1400);
    test_back_to_back(300);
    wait_drained();
    $display("Checked %0d cells under %0d glyph settings, %0d of them from transparent pixels.",
             cells_checked, glyph_phases, blank_pixels);
    $display("Color indices produced (bit per index): %b", index_seen[10:1]);
    if (errors == 0 && cell_q.size() == 0) begin
      $display("** nearest_palette_cell_mapper_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d cells never arrived", errors, cell_q.size());
      $display("** nearest_palette_cell_mapper_unit: FAILED **");
    end
    $finish;
  end

endmodule
